/* rtl/dmi_pkg.sv */
// Package for the drive-mode interlock: widths, action/mode/reject codes,
// event and result structs, the mode-code and wheel-rpm magnitude helpers.
// No dependencies.
package dmi_pkg;

    localparam int RPM_WIDTH = 16;
    localparam int LIMIT_W   = 15;
    localparam int MAG_W     = RPM_WIDTH + 1;
    localparam int CMP_W     = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef enum logic [1:0] {
        ACT_PARK  = 2'd0,
        ACT_REV   = 2'd1,
        ACT_FAULT = 2'd2,
        ACT_SPEED = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        MODE_FWD   = 4'b0001,
        MODE_REV   = 4'b0010,
        MODE_PARK  = 4'b0100,
        MODE_FAULT = 4'b1000
    } t_mode;

    typedef enum logic [1:0] {
        CODE_FWD   = 2'd0,
        CODE_REV   = 2'd1,
        CODE_PARK  = 2'd2,
        CODE_FAULT = 2'd3
    } t_mode_code;

    typedef enum logic [2:0] {
        REJ_NONE       = 3'd0,
        REJ_PARK_FAULT = 3'd1,
        REJ_PARK_FAST  = 3'd2,
        REJ_DIR_FAULT  = 3'd3,
        REJ_PARKED     = 3'd4,
        REJ_REV_FAST   = 3'd5
    } t_reject;

    typedef struct packed {
        logic [1:0]                  action;
        logic                        request_on;
        logic signed [RPM_WIDTH-1:0] left_rpm;
        logic signed [RPM_WIDTH-1:0] right_rpm;
    } t_evt;

    typedef struct packed {
        logic       accepted;
        logic [2:0] reject_code;
        logic [1:0] mode;
        logic       mode_changed;
        logic [2:0] last_reject;
    } t_res;

    function automatic logic [1:0] mode_code(input t_mode m);
        t_mode_code c;
        case (m)
            MODE_FWD:   c = CODE_FWD;
            MODE_REV:   c = CODE_REV;
            MODE_PARK:  c = CODE_PARK;
            MODE_FAULT: c = CODE_FAULT;
            default:    c = CODE_PARK;
        endcase
        return c;
    endfunction

    function automatic logic [MAG_W-1:0] rpm_mag(input logic signed [RPM_WIDTH-1:0] v);
        logic signed [MAG_W-1:0] ext;
        logic signed [MAG_W-1:0] neg;
        ext = {v[RPM_WIDTH-1], v};
        neg = -ext;
        return v[RPM_WIDTH-1] ? MAG_W'(neg) : MAG_W'(ext);
    endfunction

endpackage

/* rtl/dmi_if.sv */
// Valid/ready channel interfaces for interlock events and results.
// Depends on dmi_pkg.
interface dmi_evt_if import dmi_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic                        request_on;
    logic signed [RPM_WIDTH-1:0] left_rpm;
    logic signed [RPM_WIDTH-1:0] right_rpm;

    modport source (output valid, action, request_on, left_rpm, right_rpm, input ready);
    modport sink   (input valid, action, request_on, left_rpm, right_rpm, output ready);
endinterface

interface dmi_res_if import dmi_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [2:0] reject_code;
    logic [1:0] mode;
    logic       mode_changed;
    logic [2:0] last_reject;

    modport source (output valid, accepted, reject_code, mode, mode_changed, last_reject,
                    input ready);
    modport sink   (input valid, accepted, reject_code, mode, mode_changed, last_reject,
                    output ready);
endinterface

/* rtl/dmi_in_reg.sv */
// Input register of the interlock: captures one event beat per cycle while it is empty or its held beat is taken.
// Depends on dmi_pkg and dmi_evt_if.
module dmi_in_reg import dmi_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dmi_evt_if.sink        i_evt,
    input  logic           i_take,
    output logic           o_vld,
    output t_evt           o_evt
);

    logic r_vld;
    t_evt r_evt;
    logic load;

    assign i_evt.ready = !r_vld || i_take;
    assign load        = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_evt.action     <= i_evt.action;
            r_evt.request_on <= i_evt.request_on;
            r_evt.left_rpm   <= i_evt.left_rpm;
            r_evt.right_rpm  <= i_evt.right_rpm;
        end
    end

    assign o_vld = r_vld;
    assign o_evt = r_evt;

endmodule

/* rtl/dmi_eval.sv */
// Interlock decision logic and state: drive mode, peak wheel magnitude,
// kept reject code and the safe rpm limit register. Depends on dmi_pkg.
module dmi_eval import dmi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_fire,
    input  t_evt               i_evt,
    output t_res               o_res
);

    t_mode              r_mode;
    t_mode              n_mode;
    logic [MAG_W-1:0]   r_max_mag;
    logic [MAG_W-1:0]   n_max_mag;
    logic [2:0]         r_kept;
    logic [2:0]         n_kept;
    logic [LIMIT_W-1:0] r_limit;
    t_reject            code;
    logic               slow;
    logic [MAG_W-1:0]   mag_l;
    logic [MAG_W-1:0]   mag_r;

    assign slow  = CMP_W'(r_max_mag) <= CMP_W'(r_limit);
    assign mag_l = rpm_mag(i_evt.left_rpm);
    assign mag_r = rpm_mag(i_evt.right_rpm);

    always_comb begin
        n_mode    = r_mode;
        n_max_mag = r_max_mag;
        code      = REJ_NONE;
        case (t_action'(i_evt.action))
            ACT_PARK: begin
                if (r_mode == MODE_FAULT) begin
                    code = REJ_PARK_FAULT;
                end else if (i_evt.request_on) begin
                    n_mode = MODE_PARK;
                end else if (!slow) begin
                    code = REJ_PARK_FAST;
                end else begin
                    n_mode = MODE_FWD;
                end
            end
            ACT_REV: begin
                if (r_mode == MODE_FAULT) begin
                    code = REJ_DIR_FAULT;
                end else if (r_mode == MODE_PARK) begin
                    code = REJ_PARKED;
                end else if (i_evt.request_on && !slow) begin
                    code = REJ_REV_FAST;
                end else begin
                    n_mode = i_evt.request_on ? MODE_REV : MODE_FWD;
                end
            end
            ACT_FAULT: begin
                if (i_evt.request_on) begin
                    n_mode = MODE_FAULT;
                end else if (r_mode == MODE_FAULT) begin
                    n_mode = MODE_PARK;
                end
            end
            default: begin
                n_max_mag = (mag_l > mag_r) ? mag_l : mag_r;
            end
        endcase
        n_kept = (code != REJ_NONE) ? code : r_kept;
    end

    assign o_res.accepted     = (code == REJ_NONE);
    assign o_res.reject_code  = code;
    assign o_res.mode         = mode_code(n_mode);
    assign o_res.mode_changed = (n_mode != r_mode);
    assign o_res.last_reject  = n_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_PARK;
            r_max_mag <= '0;
            r_kept    <= REJ_NONE;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_max_mag <= n_max_mag;
            r_kept    <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

endmodule

/* rtl/dmi_out_reg.sv */
// Result register of the interlock: holds one result beat until taken.
// Depends on dmi_pkg and dmi_res_if.
module dmi_out_reg import dmi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_res      i_res,
    dmi_res_if.source o_res,
    output logic      o_free
);

    logic r_vld;
    t_res r_res;

    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_vld;
    assign o_res.accepted     = r_res.accepted;
    assign o_res.reject_code  = r_res.reject_code;
    assign o_res.mode         = r_res.mode;
    assign o_res.mode_changed = r_res.mode_changed;
    assign o_res.last_reject  = r_res.last_reject;

endmodule

/* rtl/drive_mode_interlock_core.sv */
// Drive-mode interlock top level: input register, decision logic, result register.
// Depends on dmi_pkg, dmi_if, dmi_in_reg, dmi_eval, dmi_out_reg.
//
//  channel   dir   handshake            payload
//  i_evt     in    valid/ready          action, request_on, left_rpm, right_rpm
//  o_res     out   valid/ready          accepted, reject_code, mode, mode_changed,
//                                       last_reject
//  i_cfg     in    i_cfg_we             i_cfg_data (safe rpm limit)
//
// One event per cycle unless results stall; beats pass input then result register.
// The mode and speed state update in the same cycle the event leaves the input register,
// so the next event sees it at once.
// Reset is synchronous, active low: mode park, speeds zero, no kept reject, limit 100.
// A stalled result holds the result register; the input register keeps accepting
// while it is empty or draining.
module drive_mode_interlock_core import dmi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dmi_evt_if.sink            i_evt,
    dmi_res_if.source          o_res,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic in_vld;
    t_evt in_evt;
    logic out_free;
    logic fire;
    t_res res;

    assign fire = in_vld && out_free;

    dmi_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (fire),
        .o_vld   (in_vld),
        .o_evt   (in_evt)
    );

    dmi_eval u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_evt      (in_evt),
        .o_res      (res)
    );

    dmi_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (res),
        .o_res   (o_res),
        .o_free  (out_free)
    );

`ifndef SYNTHESIS
    a_evt_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> in_vld)
        else $error("accepted event beat not held in input register");

    a_acc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.accepted == (o_res.reject_code == REJ_NONE)))
        else $error("accepted flag disagrees with reject code");

    a_kept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.reject_code != REJ_NONE))
            |-> (o_res.last_reject == o_res.reject_code))
        else $error("kept reject code does not follow refusal");

    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_res.valid)
        else $error("processed event did not produce a result beat");
`endif

endmodule

/* tb/sv/tb_drive_mode_interlock_core.sv */
// Self-checking bench for drive_mode_interlock_core: directed and random events
// with a scoreboard that predicts every result beat. Uses dmi_pkg and dmi_if.
module tb_drive_mode_interlock_core;
    import dmi_pkg::*;

    class interlock_scoreboard;
        t_mode_code                  mode;
        logic signed [RPM_WIDTH-1:0] wheel_left;
        logic signed [RPM_WIDTH-1:0] wheel_right;
        t_reject                     held_reject;
        logic [LIMIT_W-1:0]          rpm_limit;
        t_res                        outcomes[$];
        int                          fails;
        int                          beats;

        function new();
            mode        = CODE_PARK;
            wheel_left  = '0;
            wheel_right = '0;
            held_reject = REJ_NONE;
            rpm_limit   = LIMIT_RESET;
            fails       = 0;
            beats       = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            fails++;
        endtask

        function bit slow_enough();
            int a;
            int b;
            a = wheel_left;
            b = wheel_right;
            if (a < 0) a = -a;
            if (b < 0) b = -b;
            return ((a > b) ? a : b) <= int'(rpm_limit);
        endfunction

        task apply_event(input t_action act, input logic on,
                         input logic signed [RPM_WIDTH-1:0] l,
                         input logic signed [RPM_WIDTH-1:0] r);
            t_mode_code nxt;
            t_reject    code;
            t_res       want;
            nxt  = mode;
            code = REJ_NONE;
            case (act)
                ACT_PARK: begin
                    if (mode == CODE_FAULT) code = REJ_PARK_FAULT;
                    else if (on) nxt = CODE_PARK;
                    else if (!slow_enough()) code = REJ_PARK_FAST;
                    else nxt = CODE_FWD;
                end
                ACT_REV: begin
                    if (mode == CODE_FAULT) code = REJ_DIR_FAULT;
                    else if (mode == CODE_PARK) code = REJ_PARKED;
                    else if (on && !slow_enough()) code = REJ_REV_FAST;
                    else nxt = on ? CODE_REV : CODE_FWD;
                end
                ACT_FAULT: begin
                    if (on) nxt = CODE_FAULT;
                    else if (mode == CODE_FAULT) nxt = CODE_PARK;
                end
                default: begin
                    wheel_left  = l;
                    wheel_right = r;
                end
            endcase
            if (code != REJ_NONE) held_reject = code;
            want.accepted     = (code == REJ_NONE);
            want.reject_code  = code;
            want.mode         = nxt;
            want.mode_changed = (nxt != mode);
            want.last_reject  = held_reject;
            mode = nxt;
            outcomes.push_back(want);
        endtask

        task field_check(input string name, input logic [2:0] got, input logic [2:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s got %0d want %0d", beats, name, got, want));
        endtask

        task match_outcome(input t_res got);
            t_res want;
            beats++;
            if (outcomes.size() == 0) begin
                report($sformatf("beat %0d with no result pending: %p", beats, got));
                return;
            end
            want = outcomes.pop_front();
            field_check("accepted", 3'(got.accepted), 3'(want.accepted));
            field_check("reject_code", got.reject_code, want.reject_code);
            field_check("mode", 3'(got.mode), 3'(want.mode));
            field_check("mode_changed", 3'(got.mode_changed), 3'(want.mode_changed));
            field_check("last_reject", got.last_reject, want.last_reject);
        endtask
    endclass

    localparam int STALL_LIMIT = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;
    t_res               res_beat;
    int                 send_gap_pct;
    int                 recv_stall_pct;
    int                 stall_cycles = 0;
    interlock_scoreboard sb;

    dmi_evt_if evt_if ();
    dmi_res_if res_if ();

    drive_mode_interlock_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    assign res_beat = {res_if.accepted, res_if.reject_code, res_if.mode,
                       res_if.mode_changed, res_if.last_reject};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic put_event(input t_action act, input logic on,
                             input logic signed [RPM_WIDTH-1:0] l,
                             input logic signed [RPM_WIDTH-1:0] r);
        while ($urandom_range(99) < send_gap_pct) begin
            evt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.action     <= act;
        evt_if.request_on <= on;
        evt_if.left_rpm   <= l;
        evt_if.right_rpm  <= r;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        sb.apply_event(act, on, l, r);
        @(negedge i_clk);
    endtask

    function automatic logic signed [RPM_WIDTH-1:0] pick_rpm();
        int m;
        int lim;
        lim = int'(sb.rpm_limit);
        case ($urandom_range(9))
            0, 1, 2: begin
                m = lim + int'($urandom_range(4)) - 2;
                if (m < 0) m = -m;
            end
            3, 4:    m = int'($urandom_range(lim));
            5, 6, 7: return RPM_WIDTH'($urandom);
            8: begin
                case ($urandom_range(3))
                    0:       return {1'b1, {(RPM_WIDTH-1){1'b0}}};
                    1:       return {1'b0, {(RPM_WIDTH-1){1'b1}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: m = int'($urandom_range(3));
        endcase
        return $urandom_range(1) ? RPM_WIDTH'(-m) : RPM_WIDTH'(m);
    endfunction

    task automatic random_event();
        int      pick;
        t_action act;
        logic    on;
        pick = $urandom_range(99);
        if (pick < 30) begin
            act = ACT_PARK;
            on  = ($urandom_range(99) < 35);
        end else if (pick < 60) begin
            act = ACT_REV;
            on  = ($urandom_range(99) < 60);
        end else if (pick < 70) begin
            act = ACT_FAULT;
            on  = ($urandom_range(99) < 40);
        end else begin
            act = ACT_SPEED;
            on  = 1'($urandom_range(1));
        end
        put_event(act, on, pick_rpm(), pick_rpm());
    endtask

    task automatic drain();
        evt_if.valid <= 1'b0;
        while (sb.outcomes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        cfg_we       <= 1'b1;
        cfg_data     <= value;
        sb.rpm_limit  = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) sb.match_outcome(res_beat);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("** drive_mode_interlock_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        sb                = new();
        send_gap_pct      = 12;
        recv_stall_pct    = 75;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_data          = '0;
        evt_if.valid      = 1'b0;
        evt_if.action     = ACT_PARK;
        evt_if.request_on = 1'b0;
        evt_if.left_rpm   = '0;
        evt_if.right_rpm  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        put_event(ACT_REV,   1'b1, '0, '0);
        put_event(ACT_PARK,  1'b1, '0, '0);
        put_event(ACT_FAULT, 1'b0, '0, '0);
        put_event(ACT_SPEED, 1'b0, 16'sd100, -16'sd100);
        put_event(ACT_PARK,  1'b0, '0, '0);
        put_event(ACT_REV,   1'b1, '0, '0);
        put_event(ACT_PARK,  1'b0, '0, '0);
        put_event(ACT_REV,   1'b1, '0, '0);
        put_event(ACT_REV,   1'b1, '1, '1);
        put_event(ACT_REV,   1'b0, '0, '0);
        put_event(ACT_REV,   1'b0, '0, '0);
        put_event(ACT_SPEED, 1'b1, '0, -16'sd101);
        put_event(ACT_REV,   1'b1, '0, '0);
        put_event(ACT_PARK,  1'b0, '0, '0);
        put_event(ACT_PARK,  1'b1, '0, '0);
        put_event(ACT_FAULT, 1'b1, '0, '0);
        put_event(ACT_PARK,  1'b1, '0, '0);
        put_event(ACT_REV,   1'b0, '0, '0);
        put_event(ACT_FAULT, 1'b1, '0, '0);
        put_event(ACT_FAULT, 1'b0, '0, '0);
        drain();
        set_limit('1);
        put_event(ACT_SPEED, 1'b0, 16'sh8000, '0);
        put_event(ACT_PARK,  1'b0, '0, '0);
        put_event(ACT_SPEED, 1'b1, 16'sh7fff, 16'sh7fff);
        put_event(ACT_PARK,  1'b0, '0, '0);
        put_event(ACT_REV,   1'b1, '0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 12 : (phase == 1) ? 75 : 0;
            recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 12 : 0;
            for (int step = 0; step < 5; step++) begin
                drain();
                case (step)
                    0:       set_limit('0);
                    1:       set_limit('1);
                    2:       set_limit(LIMIT_W'($urandom_range(32766, 1)));
                    3:       set_limit(LIMIT_W'($urandom_range(2000, 50)));
                    default: set_limit(LIMIT_RESET);
                endcase
                repeat (110) random_event();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.outcomes.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outcomes.size()));
        if (sb.fails == 0)
            $display("** drive_mode_interlock_core: PASSED **");
        else
            $display("** drive_mode_interlock_core: FAILED **");
        $finish;
    end
endmodule
